@@ hdl/zz_pkg.sv @@
// shared types, constants and scan table for the zig-zag run-length coder
`timescale 1ns / 1ps

package zz_pkg;

    localparam int BLOCK_EDGE = 8;
    localparam int BLOCK_AREA = BLOCK_EDGE * BLOCK_EDGE;
    localparam int IDX_W      = $clog2(BLOCK_AREA);
    localparam int COEFF_W    = 12;
    localparam int RUN_W      = 6;
    localparam int RUN_FOLD_W = RUN_W + 1;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLOCK_AREA - 1);

    // raster index of each zig-zag scan position
    localparam logic [IDX_W-1:0] ZZ_ORDER [BLOCK_AREA] = '{
         0,  1,  8, 16,  9,  2,  3, 10, 17, 24, 32, 25, 18, 11,  4,  5,
        12, 19, 26, 33, 40, 48, 41, 34, 27, 20, 13,  6,  7, 14, 21, 28,
        35, 42, 49, 56, 57, 50, 43, 36, 29, 22, 15, 23, 30, 37, 44, 51,
        58, 59, 52, 45, 38, 31, 39, 46, 53, 60, 61, 54, 47, 55, 62, 63
    };

    // one scanned coefficient, classified by the front part
    typedef struct packed {
        logic signed [COEFF_W-1:0] value;
        logic                      is_dc;
        logic                      is_zero;
        logic                      is_last;
    } t_token;

    // one result item
    typedef struct packed {
        logic [RUN_W-1:0]          run_length;
        logic                      run_present;
        logic signed [COEFF_W-1:0] coeff_value;
        logic                      coeff_present;
        logic [COEFF_W-1:0]        coeff_folded;
        logic [RUN_FOLD_W-1:0]     run_folded;
        logic                      block_end;
    } t_result;

    // 2v for v >= 0, -2v-1 otherwise
    function automatic logic [COEFF_W-1:0] fold_coeff(logic signed [COEFF_W-1:0] v);
        return {v[COEFF_W-2:0], 1'b0} ^ {COEFF_W{v[COEFF_W-1]}};
    endfunction

endpackage

@@ hdl/zz_front.sv @@
// coefficient buffer, block loader and zig-zag scanner
`timescale 1ns / 1ps

module zz_front import zz_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic signed [COEFF_W-1:0] i_coeff,
    output logic                      o_full,
    input  logic [QCNT_W-1:0]         i_q_count,
    output logic                      o_tok_push,
    output t_token                    o_tok
);

    logic signed [COEFF_W-1:0] r_buffer [BLOCK_AREA];
    logic [IDX_W-1:0]          r_load_pos;
    logic                      r_scan_active;
    logic [IDX_W-1:0]          r_scan_idx;
    logic                      r_rd_valid;
    logic [IDX_W-1:0]          r_rd_idx;
    logic signed [COEFF_W-1:0] r_rd_data;

    logic accept;
    logic issue;

    assign o_full = r_scan_active;
    assign accept = i_push && !r_scan_active;
    // keep room in the queue for the read still in flight
    assign issue  = r_scan_active &&
                    ((i_q_count + QCNT_W'(r_rd_valid)) < QCNT_W'(QDEPTH));

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_buffer[r_load_pos] <= i_coeff;
        end
        if (issue) begin
            r_rd_data <= r_buffer[ZZ_ORDER[r_scan_idx]];
            r_rd_idx  <= r_scan_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_pos    <= '0;
            r_scan_active <= 1'b0;
            r_scan_idx    <= '0;
            r_rd_valid    <= 1'b0;
        end else begin
            r_rd_valid <= issue;
            if (accept) begin
                r_load_pos <= r_load_pos + 1'b1;
                if (r_load_pos == LAST_IDX) begin
                    r_scan_active <= 1'b1;
                    r_scan_idx    <= '0;
                end
            end
            if (issue) begin
                r_scan_idx <= r_scan_idx + 1'b1;
                if (r_scan_idx == LAST_IDX) begin
                    r_scan_active <= 1'b0;
                end
            end
        end
    end

    assign o_tok_push    = r_rd_valid;
    assign o_tok.value   = r_rd_data;
    assign o_tok.is_dc   = (r_rd_idx == '0);
    assign o_tok.is_zero = (r_rd_data == '0);
    assign o_tok.is_last = (r_rd_idx == LAST_IDX);

endmodule

@@ hdl/zz_fifo.sv @@
// short token queue between scanner and run-length stage
`timescale 1ns / 1ps

module zz_fifo import zz_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_token            i_tok,
    input  logic              i_pop,
    output t_token            o_tok,
    output logic              o_empty,
    output logic [QCNT_W-1:0] o_count
);

    t_token              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;

    logic do_pop;

    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_tok   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ hdl/zz_back.sv @@
// zero-run counting and result formatting with output register
`timescale 1ns / 1ps

module zz_back import zz_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_token  i_tok,
    input  logic    i_tok_empty,
    output logic    o_tok_pop,
    output t_result o_res,
    output logic    o_empty,
    input  logic    i_pop
);

    logic [RUN_W-1:0] r_zeros;
    logic [RUN_W-1:0] n_zeros;
    t_result          r_res;
    t_result          n_res;
    logic             r_res_valid;

    logic out_free;
    logic emits;
    logic take;

    assign out_free  = !r_res_valid || i_pop;
    // an inner zero only bumps the run, so it never waits on the output
    assign emits     = i_tok.is_dc || !i_tok.is_zero || i_tok.is_last;
    assign take      = !i_tok_empty && (!emits || out_free);
    assign o_tok_pop = take;
    assign o_empty   = !r_res_valid;
    assign o_res     = r_res;

    always_comb begin
        n_zeros             = r_zeros;
        n_res.run_length    = '0;
        n_res.run_present   = 1'b0;
        n_res.coeff_value   = '0;
        n_res.coeff_present = 1'b0;
        n_res.block_end     = i_tok.is_last;
        if (i_tok.is_dc) begin
            n_res.coeff_value   = i_tok.value;
            n_res.coeff_present = 1'b1;
            n_zeros             = '0;
        end else if (i_tok.is_zero) begin
            n_zeros           = r_zeros + 1'b1;
            n_res.run_length  = r_zeros + 1'b1;
            n_res.run_present = 1'b1;
        end else begin
            n_res.run_length    = r_zeros;
            n_res.run_present   = 1'b1;
            n_res.coeff_value   = i_tok.value;
            n_res.coeff_present = 1'b1;
            n_zeros             = '0;
        end
        n_res.coeff_folded = n_res.coeff_present ? fold_coeff(n_res.coeff_value) : '0;
        n_res.run_folded   = {n_res.run_length, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (take && emits) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zeros     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (take) begin
                r_zeros <= n_zeros;
            end
            if (take && emits) begin
                r_res_valid <= 1'b1;
            end else if (i_pop) begin
                r_res_valid <= 1'b0;
            end
        end
    end

endmodule

@@ hdl/zigzag_run_length_coder_8x8.sv @@
// top level of the 8x8 zig-zag run-length coder
//
//  channel   handshake            payload
//  -------   ------------------   -------------------------------------------
//  input     push / full          i_coeff (12b signed, raster order)
//  result    empty / pop          o_run_length, o_run_present, o_coeff_value,
//                                 o_coeff_present, o_coeff_folded,
//                                 o_run_folded, o_block_end
//
//  a block is loaded one coefficient per cycle, then full stays high for
//  the zig-zag scan (one buffer read per cycle while the scan is not paused)
//  the scan pauses while the 4-entry token queue has no room, so a stalled
//  result side holds the scan back but never loses a result
//  loading of the next block overlaps the drain of the previous one
//  reset clears counters and valid flags only; the buffer is not cleared
`timescale 1ns / 1ps

module zigzag_run_length_coder_8x8 import zz_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input transaction
    input  logic                      push,
    input  logic signed [COEFF_W-1:0] i_coeff,
    output logic                      full,
    // result transaction
    output logic                      empty,
    input  logic                      pop,
    output logic [RUN_W-1:0]          o_run_length,
    output logic                      o_run_present,
    output logic signed [COEFF_W-1:0] o_coeff_value,
    output logic                      o_coeff_present,
    output logic [COEFF_W-1:0]        o_coeff_folded,
    output logic [RUN_FOLD_W-1:0]     o_run_folded,
    output logic                      o_block_end
);

    // scanner to queue
    t_token            front_tok;
    logic              front_push;
    // queue to run-length stage
    t_token            q_tok;
    logic              q_empty;
    logic              q_pop;
    logic [QCNT_W-1:0] q_count;
    // formatted result
    t_result           res;

    // load raster coefficients, scan in zig-zag order, classify each one
    zz_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_coeff    (i_coeff),
        .o_full     (full),
        .i_q_count  (q_count),
        .o_tok_push (front_push),
        .o_tok      (front_tok)
    );

    // decouples the scanner from the result side
    zz_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_tok   (front_tok),
        .i_pop   (q_pop),
        .o_tok   (q_tok),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    // count zero runs and build each result transaction
    zz_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok       (q_tok),
        .i_tok_empty (q_empty),
        .o_tok_pop   (q_pop),
        .o_res       (res),
        .o_empty     (empty),
        .i_pop       (pop)
    );

    // unpack the result onto its ports
    assign o_run_length    = res.run_length;
    assign o_run_present   = res.run_present;
    assign o_coeff_value   = res.coeff_value;
    assign o_coeff_present = res.coeff_present;
    assign o_coeff_folded  = res.coeff_folded;
    assign o_run_folded    = res.run_folded;
    assign o_block_end     = res.block_end;

endmodule
